### sv/hdc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hdc_pkg
// Shared types and constants of the hashed distinct counter.
// ----------------------------------------------------------------------------
package hdc_pkg;

    localparam int SLOT_INDEX_BITS_DEF = 16;
    localparam int EPOCH_BITS          = 8;
    localparam int COUNT_BITS          = 17;
    localparam int HASH_BITS           = 32;

    localparam logic [HASH_BITS-1:0] FNV_BASIS = 32'd2166136261;
    localparam logic [HASH_BITS-1:0] FNV_PRIME = 32'd16777619;

    localparam logic [1:0] FUNC_ABSORB = 2'd0;
    localparam logic [1:0] FUNC_END    = 2'd1;
    localparam logic [1:0] FUNC_START  = 2'd2;
    localparam logic [1:0] FUNC_NOP    = 2'd3;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] data_byte;
    } t_in;

    typedef struct packed {
        logic [COUNT_BITS-1:0] distinct_count;
        logic                  was_new;
        logic [HASH_BITS-1:0]  hash_value;
    } t_out;

    typedef struct packed {
        logic       absorb;
        logic       restart;
        logic [7:0] data_byte;
    } t_hash_ctl;

endpackage
`default_nettype wire

### sv/hdc_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hdc_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module hdc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

### sv/hdc_hash_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hdc_hash_unit
// Running FNV-1a 32-bit hash register with its byte fold datapath.
// ----------------------------------------------------------------------------
module hdc_hash_unit
    import hdc_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_hash_ctl            i_ctl,
    output logic      [HASH_BITS-1:0] o_hash,
    output logic      [HASH_BITS-1:0] o_folded
);

    logic [HASH_BITS-1:0] r_hash;
    logic [HASH_BITS-1:0] n_hash;
    logic [HASH_BITS-1:0] w_mix;

    assign w_mix    = r_hash ^ {{(HASH_BITS-8){1'b0}}, i_ctl.data_byte};
    assign o_folded = w_mix * FNV_PRIME;
    assign o_hash   = r_hash;

    always_comb begin
        priority if (i_ctl.restart) begin
            n_hash = FNV_BASIS;
        end else if (i_ctl.absorb) begin
            n_hash = o_folded;
        end else begin
            n_hash = r_hash;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= FNV_BASIS;
        end else begin
            r_hash <= n_hash;
        end
    end

endmodule
`default_nettype wire

### sv/hashed_distinct_counter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hashed_distinct_counter
// Counts distinct values of a batch by FNV-1a hashing into a seen-bitmap.
// ----------------------------------------------------------------------------
// Input channel i_in_*: one transaction per item (absorb byte, end value,
// start batch). Output channel o_out_*: exactly one result per item, in order.
// For absorb, start and unused codes the result appears the cycle after
// acceptance. An end item first does a registered read of the slot memory,
// then tests, writes back and registers the result in the lookup state.
// The seen-bitmap is a memory of epoch tags, 2**SLOT_INDEX_BITS entries deep;
// a slot is seen when its tag equals the current epoch. A start item bumps the
// epoch. After reset, and after every 255th start item, a clearing pass writes
// zero to all 2**SLOT_INDEX_BITS entries, one per cycle, with input stalled.
// The result register lets the next item in at the same edge the pending
// result is taken; while the receiver stalls with a result pending, o_in_stall
// stays high and the result holds.
// ----------------------------------------------------------------------------
module hashed_distinct_counter
    import hdc_pkg::*;
#(
    parameter int SLOT_INDEX_BITS = SLOT_INDEX_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_stall,
    input  wire t_in  i_in_data,
    output logic      o_out_valid,
    input  wire logic i_out_stall,
    output t_out      o_out_data
);

    localparam int DEPTH = 1 << SLOT_INDEX_BITS;

    typedef enum logic [2:0] {
        ST_CLEAR  = 3'b001,
        ST_IDLE   = 3'b010,
        ST_LOOKUP = 3'b100
    } t_state;

    t_state                     r_state, n_state;
    logic [SLOT_INDEX_BITS-1:0] r_clr_cnt, n_clr_cnt;
    logic [EPOCH_BITS-1:0]      r_epoch, n_epoch;
    logic [COUNT_BITS-1:0]      r_count, n_count;
    logic                       r_out_valid, n_out_valid;
    t_out                       r_out, n_out;
    logic [SLOT_INDEX_BITS-1:0] r_slot;
    logic [HASH_BITS-1:0]       r_end_hash;

    logic                       w_accept;
    logic                       w_hit;
    t_hash_ctl                  w_hctl;
    logic [HASH_BITS-1:0]       w_hash;
    logic [HASH_BITS-1:0]       w_folded;
    logic                       w_we;
    logic [SLOT_INDEX_BITS-1:0] w_waddr;
    logic [EPOCH_BITS-1:0]      w_wdata;
    logic [EPOCH_BITS-1:0]      w_rdata;

    assign o_in_stall = (r_state != ST_IDLE) || (r_out_valid && i_out_stall);
    assign w_accept   = i_in_valid && !o_in_stall;

    assign w_hctl.absorb    = w_accept && (i_in_data.func == FUNC_ABSORB);
    assign w_hctl.restart   = w_accept && ((i_in_data.func == FUNC_END)
                                        || (i_in_data.func == FUNC_START));
    assign w_hctl.data_byte = i_in_data.data_byte;

    hdc_hash_unit u_hash (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_hctl),
        .o_hash   (w_hash),
        .o_folded (w_folded)
    );

    hdc_ram #(
        .WIDTH (EPOCH_BITS),
        .DEPTH (DEPTH)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_hash[SLOT_INDEX_BITS-1:0]),
        .o_rdata (w_rdata)
    );

    assign w_hit = (w_rdata == r_epoch);

    always_comb begin
        n_state     = r_state;
        n_clr_cnt   = r_clr_cnt;
        n_epoch     = r_epoch;
        n_count     = r_count;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        w_we        = 1'b0;
        w_waddr     = r_slot;
        w_wdata     = r_epoch;

        unique case (r_state)
            ST_CLEAR: begin
                w_we      = 1'b1;
                w_waddr   = r_clr_cnt;
                w_wdata   = '0;
                n_clr_cnt = r_clr_cnt + 1'b1;
                if (&r_clr_cnt) begin
                    n_state = ST_IDLE;
                    n_epoch = EPOCH_BITS'(1);
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    n_out.was_new = 1'b0;
                    unique case (i_in_data.func)
                        FUNC_ABSORB: begin
                            n_out_valid          = 1'b1;
                            n_out.distinct_count = r_count;
                            n_out.hash_value     = w_folded;
                        end
                        FUNC_END: begin
                            n_state = ST_LOOKUP;
                        end
                        FUNC_START: begin
                            n_out_valid          = 1'b1;
                            n_count              = '0;
                            n_out.distinct_count = '0;
                            n_out.hash_value     = FNV_BASIS;
                            if (&r_epoch) begin
                                n_state   = ST_CLEAR;
                                n_clr_cnt = '0;
                            end else begin
                                n_epoch = r_epoch + 1'b1;
                            end
                        end
                        FUNC_NOP: begin
                            n_out_valid          = 1'b1;
                            n_out.distinct_count = r_count;
                            n_out.hash_value     = w_hash;
                        end
                    endcase
                end
            end
            ST_LOOKUP: begin
                n_state          = ST_IDLE;
                n_out_valid      = 1'b1;
                n_out.was_new    = !w_hit;
                n_out.hash_value = r_end_hash;
                if (!w_hit) begin
                    w_we = 1'b1;
                    if (!(&r_count)) begin
                        n_count = r_count + 1'b1;
                    end
                end
                n_out.distinct_count = n_count;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_cnt   <= '0;
            r_epoch     <= EPOCH_BITS'(1);
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_cnt   <= n_clr_cnt;
            r_epoch     <= n_epoch;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (w_accept) begin
            r_slot     <= w_hash[SLOT_INDEX_BITS-1:0];
            r_end_hash <= w_hash;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire
